// File: rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 hasher.
// Depends on nothing; every other file in rtl/ imports it.
package sha256_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 64;

	localparam logic [31:0] PAD_MARK = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [2:0]  FULL_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  valid_bytes;
		logic        is_last;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_t;

	// queue entry: word already masked and marked, byte count saturated
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} q_entry_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} st_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: rtl/sha256_front.sv
// Input side of the hasher: accepts message beats and classifies them.
// Saturates the byte count, masks unused bytes and inserts the 0x80 marker.
// Depends on sha256_pkg.
module sha256_front (
	input  logic                 msg_valid,
	output logic                 msg_ready,
	input  sha256_pkg::in_t      msg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output sha256_pkg::q_entry_t push_data
);
	import sha256_pkg::*;

	logic [2:0] nb;

	always_comb begin
		if (!msg.is_last) begin
			nb = FULL_BYTES;
		end else if (msg.valid_bytes inside {[3'd5:3'd7]}) begin
			nb = FULL_BYTES;
		end else begin
			nb = msg.valid_bytes;
		end
	end

	always_comb begin
		case (nb)
			3'd0: push_data.word = PAD_MARK;
			3'd1: push_data.word = {msg.msg_word[31:24], PAD_BYTE, 16'h0000};
			3'd2: push_data.word = {msg.msg_word[31:16], PAD_BYTE, 8'h00};
			3'd3: push_data.word = {msg.msg_word[31:8], PAD_BYTE};
			default: push_data.word = msg.msg_word;
		endcase
		push_data.nbytes = nb;
		push_data.last   = msg.is_last;
	end

	assign push_valid       = msg_valid;
	assign msg_ready        = push_ready;

endmodule

// File: rtl/sha256_fifo.sv
// Short queue between the input classifier and the compression engine.
// Depends on sha256_pkg for the entry type.
module sha256_fifo #(
	parameter int unsigned DEPTH = sha256_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  sha256_pkg::q_entry_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output sha256_pkg::q_entry_t pop_data
);
	import sha256_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/sha256_back.sv
// Compression engine: 16-word schedule shift line, one round per cycle,
// padding sequencer and digest output register. Depends on sha256_pkg.
module sha256_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  sha256_pkg::q_entry_t q_data,
	output logic                 dig_valid,
	input  logic                 dig_ready,
	output sha256_pkg::out_t     dig
);
	import sha256_pkg::*;

	st_t          st_q, st_d;
	logic [3:0]   cnt_q;        // words in the schedule line
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         padding_q, mark_q, lenblk_q;
	logic [63:0]  blen_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [BLOCK_WORDS];
	logic         ovalid_q;
	out_t         out_q;

	// control
	logic         pop, shift_en, start_cmp, load_out;
	logic [31:0]  shift_word, pad_word, sched_new;
	logic [31:0]  t1, t2;

	assign q_ready   = pop;
	assign dig_valid = ovalid_q;
	assign dig       = out_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_FILL: begin
				if (q_valid) begin
					if (cnt_q == 4'd15) begin
						st_d = ST_ROUND;
					end else if (q_data.last) begin
						st_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (cnt_q == 4'd15) begin
					st_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'(ROUNDS - 1)) begin
					st_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!padding_q) begin
					st_d = ST_FILL;
				end else if (lenblk_q) begin
					st_d = ST_OUT;
				end else begin
					st_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (load_out && oidx_q == 3'd7) begin
					st_d = ST_FILL;
				end
			end
			default: st_d = ST_FILL;
		endcase
	end

	// padding word: marker, zeros, then the length in the last two slots
	always_comb begin
		if (mark_q) begin
			pad_word = PAD_MARK;
		end else if (lenblk_q && cnt_q == 4'd14) begin
			pad_word = blen_q[63:32];
		end else if (lenblk_q && cnt_q == 4'd15) begin
			pad_word = blen_q[31:0];
		end else begin
			pad_word = '0;
		end
	end

	assign sched_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ K[rnd_q] + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// outputs of the sequencer
	always_comb begin
		pop        = 1'b0;
		shift_en   = 1'b0;
		start_cmp  = 1'b0;
		load_out   = 1'b0;
		shift_word = sched_new;
		case (st_q)
			ST_FILL: begin
				pop        = q_valid;
				shift_en   = q_valid;
				start_cmp  = q_valid && (cnt_q == 4'd15);
				shift_word = q_data.word;
			end
			ST_PAD: begin
				shift_en   = 1'b1;
				start_cmp  = (cnt_q == 4'd15);
				shift_word = pad_word;
			end
			ST_ROUND: begin
				shift_en   = 1'b1;
			end
			ST_OUT: begin
				load_out   = !ovalid_q || dig_ready;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= shift_word;
		end
		if (start_cmp) begin
			v_q <= chain_q;
		end else if (st_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (load_out) begin
			out_q.digest_word <= chain_q[oidx_q];
			out_q.word_index  <= oidx_q;
			out_q.digest_last <= (oidx_q == 3'd7);
		end
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_FILL;
			cnt_q     <= '0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			padding_q <= 1'b0;
			mark_q    <= 1'b0;
			lenblk_q  <= 1'b0;
			blen_q    <= '0;
			chain_q   <= IV;
			ovalid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (shift_en && st_q != ST_ROUND) begin
				cnt_q <= start_cmp ? '0 : cnt_q + 1'b1;
			end
			if (start_cmp) begin
				rnd_q <= '0;
			end else if (st_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end

			if (pop) begin
				blen_q <= blen_q + {58'd0, q_data.nbytes, 3'b000};
				if (q_data.last) begin
					padding_q <= 1'b1;
					mark_q    <= (q_data.nbytes == FULL_BYTES);
					lenblk_q  <= (cnt_q <= 4'd13);
				end
			end
			if (st_q == ST_PAD && mark_q) begin
				mark_q   <= 1'b0;
				lenblk_q <= (cnt_q <= 4'd13);
			end
			if (st_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
				// block ended before the length fit: next block carries it
				if (padding_q && !lenblk_q) begin
					lenblk_q <= 1'b1;
				end
			end

			if (load_out) begin
				ovalid_q <= 1'b1;
				oidx_q   <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					chain_q   <= IV;
					blen_q    <= '0;
					padding_q <= 1'b0;
					lenblk_q  <= 1'b0;
				end
			end else if (dig_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/sha256_hash.sv
// SHA-256 hasher. Message words enter big-endian, one beat each, on msg; the
// beat marked is_last carries 0..4 bytes and closes the message, after which
// eight digest beats leave on dig, word_index 0 first. The engine takes one
// queued word per cycle into its schedule line while it fills a block and
// runs one round per cycle; a full 64-byte block is filled, run through the
// 64 rounds and added into the chaining state, and the engine takes no new
// words while it compresses. The closing beat adds the padding words and one
// or two compressions, then 8 output beats. A short input queue lets message
// beats be taken while the engine compresses.
// Depends on sha256_pkg, sha256_front, sha256_fifo and sha256_back.
module sha256_hash #(
	parameter int unsigned QDEPTH = sha256_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	output logic             msg_ready,
	input  sha256_pkg::in_t  msg,
	output logic             dig_valid,
	input  logic             dig_ready,
	output sha256_pkg::out_t dig
);
	import sha256_pkg::*;

	logic     push_valid, push_ready, q_valid, q_ready;
	q_entry_t push_data, q_data;

	sha256_front u_front (
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sha256_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	sha256_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

endmodule

// File: tb/testbench.sv
// Self-checking bench for sha256_hash: random and directed messages go in on msg,
// a scoreboard hashes them on its own and checks every digest beat on dig.
// Depends on sha256_pkg (beat types) and the sha256_hash RTL.

import sha256_pkg::in_t;
import sha256_pkg::out_t;

localparam logic [31:0] HASH_INIT [8] = '{
	32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
	32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

localparam logic [31:0] ROUND_K [64] = '{
	32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
	32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
	32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
	32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
	32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
	32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
	32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
	32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
	32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
	32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
	32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
	32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
	32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
	32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
	32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
	32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

localparam logic [31:0] PAD_WORD = 32'h8000_0000;

class digest_scoreboard;
	logic [31:0] chain [8];
	logic [31:0] block [16];
	int          fill_words;
	logic [63:0] msg_bits;
	out_t        digest_q [$];
	int          errors;

	function new();
		chain = HASH_INIT;
		fill_words = 0;
		msg_bits = '0;
		errors = 0;
	endfunction

	function logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function void compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = block[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		v = chain;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function void note_input(in_t beat);
		logic [31:0] word;
		int          nb;
		out_t        want;
		word = beat.msg_word;
		if (!beat.is_last) begin
			// byte count on a middle beat is ignored
			block[fill_words] = word;
			msg_bits = msg_bits + 64'd32;
			fill_words++;
			if (fill_words == 16) begin
				compress();
				fill_words = 0;
			end
			return;
		end
		nb = (beat.valid_bytes > 3'd4) ? 4 : int'(beat.valid_bytes);
		msg_bits = msg_bits + 64'(nb * 8);
		if (nb < 4)
			word = (word & (32'hFFFF_FFFF << (32 - 8 * nb))) | (32'h80 << (24 - 8 * nb));
		block[fill_words] = word;
		fill_words++;
		if (nb == 4) begin
			if (fill_words == 16) begin
				compress();
				fill_words = 0;
			end
			block[fill_words] = PAD_WORD;
			fill_words++;
		end
		for (int i = fill_words; i < 16; i++)
			block[i] = '0;
		// no room left for the length: spill into an extra block
		if (fill_words > 14) begin
			compress();
			for (int i = 0; i < 16; i++)
				block[i] = '0;
		end
		block[14] = msg_bits[63:32];
		block[15] = msg_bits[31:0];
		compress();
		for (int i = 0; i < 8; i++) begin
			want.digest_word = chain[i];
			want.word_index = 3'(i);
			want.digest_last = (i == 7);
			digest_q.push_back(want);
		end
		chain = HASH_INIT;
		fill_words = 0;
		msg_bits = '0;
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(out_t got);
		out_t want;
		if (digest_q.size() == 0) begin
			report($sformatf("digest beat %h with none pending", got));
			return;
		end
		want = digest_q.pop_front();
		if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
				|| got.digest_last !== want.digest_last)
			report($sformatf("word %h idx %0d last %b, want %h idx %0d last %b",
				got.digest_word, got.word_index, got.digest_last,
				want.digest_word, want.word_index, want.digest_last));
	endtask

	function int pending();
		return digest_q.size();
	endfunction
endclass

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_BEATS = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	in_t  msg = '0;
	logic dig_valid;
	logic dig_ready;
	out_t dig;

	bit   quiet = 1'b0;
	bit   hold_sink = 1'b0;
	bit   held = 1'b0;
	int   cycle_count = 0;

	digest_scoreboard sb = new();

	sha256_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg      (msg),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig      (dig)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dig_valid && dig_ready)
			sb.check_result(dig);
	end

	// digest sink: random backpressure, one long hold-off on request
	initial begin
		dig_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink && !held) begin
				dig_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			dig_ready <= quiet || ($urandom_range(99) >= 12);
		end
	end

	function automatic in_t beat_of(logic [31:0] word, logic [2:0] nb, logic last);
		in_t b;
		b.msg_word = word;
		b.valid_bytes = nb;
		b.is_last = last;
		return b;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(in_t beat);
		while (!quiet && $urandom_range(99) < 12) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg <= beat;
		msg_valid <= 1'b1;
		do @(posedge clk); while (!msg_ready);
		sb.note_input(beat);
		@(negedge clk);
	endtask

	task automatic send_message(int nwords);
		for (int i = 0; i < nwords; i++)
			send_beat(beat_of($urandom,
				($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0));
		send_beat(beat_of($urandom, 3'($urandom_range(7)), 1'b1));
	endtask

	task automatic drain();
		msg_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int sent;
		int msg_no;
		int nwords;
		int pick;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, then each byte count on a lone closing beat (5..7 saturate)
		send_beat(beat_of(32'hFFFF_FFFF, 3'd0, 1'b1));
		send_beat(beat_of(32'hFFFF_FFFF, 3'd1, 1'b1));
		send_beat(beat_of(32'h0000_0000, 3'd2, 1'b1));
		send_beat(beat_of(32'hFFFF_FFFF, 3'd3, 1'b1));
		send_beat(beat_of(32'h0000_0000, 3'd4, 1'b1));
		send_beat(beat_of(32'hFFFF_FFFF, 3'd5, 1'b1));
		send_beat(beat_of(32'h0000_0000, 3'd6, 1'b1));
		send_beat(beat_of(32'hFFFF_FFFF, 3'd7, 1'b1));
		// middle beat with a short count still counts as a full word
		send_beat(beat_of(32'hA5A5_5A5A, 3'd0, 1'b0));
		send_beat(beat_of(32'hFFFF_FFFF, 3'd0, 1'b1));
		// 56 bytes: pad marker lands in word 14, length needs an extra block
		for (int i = 0; i < 13; i++)
			send_beat(beat_of((i % 2) ? 32'hFFFF_FFFF : $urandom, 3'd4, 1'b0));
		send_beat(beat_of(32'h0000_0000, 3'd4, 1'b1));
		drain();

		sent = 0;
		msg_no = 0;
		while (sent < RANDOM_BEATS || msg_no < 12) begin
			if (msg_no == 2)
				hold_sink = 1'b1;
			quiet = (msg_no >= 6 && msg_no < 10);
			if (msg_no == 11)
				drain();
			pick = $urandom_range(9);
			if (pick < 6)
				nwords = $urandom_range(10);
			else if (pick < 9)
				nwords = $urandom_range(17, 12);
			else
				nwords = $urandom_range(40, 18);
			send_message(nwords);
			sent += nwords + 1;
			msg_no++;
		end
		quiet = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
